// ===== design/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue / heapsort core.
// Holds field widths, the datapath micro-op codes and the status bundle.
// No dependencies.
package mhpq_pkg;

	localparam int KEY_W        = 32;
	localparam int COUNT_W      = 6;
	localparam int DEF_CAPACITY = 32;

	// Stream packing: input tdata = key; output tdata = value, count, dropped, pad
	localparam int IN_DATA_W  = KEY_W;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - KEY_W - COUNT_W - 1;

	// Datapath micro-ops, one per cycle from the controller
	typedef enum logic [4:0] {
		OP_IDLE,
		OP_INS_START,  // latch key, hole at end of heap, bump count
		OP_DROP,       // full heap: flag the insert as dropped
		OP_EMPTY,      // sort of an empty heap
		OP_UP_READ,    // read parent of hole
		OP_UP_MOVE,    // parent moves down into hole
		OP_PUT,        // moving key lands at hole
		OP_SORT_START, // heap size = count
		OP_RND_RDLAST, // read last heap entry
		OP_RND_RDROOT, // latch last entry as moving key, read root
		OP_RND_MOVE,   // root goes to the end, heap shrinks
		OP_DN_RDL,     // read left child
		OP_DN_RDR,     // latch left child, read right child
		OP_DN_TAKE_LD, // only child (fresh read data) moves up
		OP_DN_TAKE_L,  // latched left child moves up
		OP_DN_TAKE_R,  // right child moves up
		OP_DRN_START,  // drain index = 0
		OP_DRN_READ,   // read entry at drain index
		OP_RES_INS,    // load insert / empty-sort result
		OP_RES_DRN     // load one drained key
	} dp_op_e;

	// Datapath status seen by the controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic size_zero;
		logic l_in;     // left child inside the heap
		logic r_in;     // right child inside the heap
		logic up_gt;    // moving key > read data
		logic rd_gt;    // read data > moving key
		logic lv_gt;    // latched left > moving key
		logic lr_gt;    // latched left > read data
		logic drn_last; // drain index is the final entry
	} dp_stat_t;

endpackage

// ===== design/max_heap_priority_queue_sort_core.sv =====
// Max-heap priority queue with heapsort drain.
// Top level: joins mhpq_ctrl and mhpq_datapath. Depends on mhpq_pkg.
//
// Input channel s_*: one item per handshake; s_tuser is the mode
// (0 = insert s_tdata as a signed key, 1 = sort and drain).
// Output channel m_*: an insert gives one item with the new count (dropped
// set and count unchanged when the heap is full). A sort gives every held
// key in ascending order, m_tuser set, m_tlast on the final one, and leaves
// the heap empty; sorting an empty heap gives one item with m_tuser low.
// Insert: the key climbs up to log2 of CAPACITY levels, each level one parent
// read and one write through the single read port of the store. A sort runs
// one round per held key: read the last entry and the root, move the root to
// the end, then sift the last entry down, reading the left and, if present,
// the right child at each level; the drain then reads and sends each key in
// turn, all via the one-read-port store. s_tready is high only when idle, and a
// new item is taken while the last result still waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// controller waits before loading the next one. Reset empties the heap;
// store contents are not cleared (entries are read only after being written).
module max_heap_priority_queue_sort_core #(
	parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mhpq_pkg::IN_DATA_W-1:0]   s_tdata,  // [31:0] key
	input  logic                             s_tuser,  // [0] mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mhpq_pkg::OUT_DATA_W-1:0]  m_tdata,  // [31:0] value, [37:32] count,
	                                                   // [38] dropped, [39] zero
	output logic                             m_tuser,  // [0] value_valid
	output logic                             m_tlast
);
	import mhpq_pkg::*;

	dp_op_e                  op;
	dp_stat_t                stat;
	logic signed [KEY_W-1:0] out_value;
	logic [COUNT_W-1:0]      out_count;
	logic                    out_dropped;

	mhpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_mode  (s_tuser),
		.s_tready(s_tready),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.stat    (stat),
		.op      (op)
	);

	mhpq_datapath #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.key        (s_tdata),
		.stat       (stat),
		.out_value  (out_value),
		.out_vflag  (m_tuser),
		.out_last   (m_tlast),
		.out_count  (out_count),
		.out_dropped(out_dropped)
	);

	// output packing
	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_dropped, out_count, out_value};

endmodule

// ===== design/mhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the heap store. No dependencies.
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/mhpq_datapath.sv =====
// Heap datapath: heap store RAM, count/size/index registers, key registers,
// comparators and the output register. Driven by micro-ops from mhpq_ctrl.
// Depends on mhpq_pkg and mhpq_ram.
module mhpq_datapath #(
	parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mhpq_pkg::dp_op_e                  op,
	input  logic signed [mhpq_pkg::KEY_W-1:0] key,
	output mhpq_pkg::dp_stat_t                stat,
	output logic signed [mhpq_pkg::KEY_W-1:0] out_value,
	output logic                              out_vflag,
	output logic                              out_last,
	output logic [mhpq_pkg::COUNT_W-1:0]      out_count,
	output logic                              out_dropped
);
	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;

	logic [CW-1:0]           cnt_q, size_q;
	logic [AW-1:0]           pos_q;
	logic signed [KEY_W-1:0] mkey_q, lval_q;
	logic                    drop_q;

	logic                    rd_en, wr_en;
	logic [AW-1:0]           rd_addr, wr_addr;
	logic [KEY_W-1:0]        wr_data, rdata_raw;
	logic signed [KEY_W-1:0] rdata;

	logic [AW-1:0] parent, last_idx;
	logic [IW-1:0] l_idx, r_idx;

	assign rdata = rdata_raw;

	// heap index arithmetic
	assign parent   = AW'((pos_q - AW'(1)) >> 1);
	assign last_idx = AW'(size_q - CW'(1));
	assign l_idx    = (IW'(pos_q) << 1) | IW'(1);
	assign r_idx    = l_idx + IW'(1);

	// status back to the controller
	always_comb begin
		stat.full      = (cnt_q == CW'(CAPACITY));
		stat.empty     = (cnt_q == '0);
		stat.pos_zero  = (pos_q == '0);
		stat.size_zero = (size_q == '0);
		stat.l_in      = (l_idx < IW'(size_q));
		stat.r_in      = (r_idx < IW'(size_q));
		stat.up_gt     = (mkey_q > rdata);
		stat.rd_gt     = (rdata > mkey_q);
		stat.lv_gt     = (lval_q > mkey_q);
		stat.lr_gt     = (lval_q > rdata);
		stat.drn_last  = ((IW'(pos_q) + IW'(1)) == IW'(cnt_q));
	end

	// RAM port steering
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = mkey_q;
		case (op)
			OP_UP_READ: begin
				rd_en   = 1'b1;
				rd_addr = parent;
			end
			OP_UP_MOVE, OP_DN_TAKE_LD, OP_DN_TAKE_R: begin
				wr_en   = 1'b1;
				wr_data = rdata;
			end
			OP_PUT: begin
				wr_en = 1'b1;
			end
			OP_RND_RDLAST: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
			end
			OP_RND_RDROOT: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			OP_RND_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = last_idx;
				wr_data = rdata;
			end
			OP_DN_RDL: begin
				rd_en   = 1'b1;
				rd_addr = l_idx[AW-1:0];
			end
			OP_DN_RDR: begin
				rd_en   = 1'b1;
				rd_addr = r_idx[AW-1:0];
			end
			OP_DN_TAKE_L: begin
				wr_en   = 1'b1;
				wr_data = lval_q;
			end
			OP_DRN_READ: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mhpq_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata_raw)
	);

	// control registers: count, heap size, hole index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			size_q <= '0;
			pos_q  <= '0;
		end else begin
			case (op)
				OP_INS_START: begin
					pos_q <= AW'(cnt_q);
					cnt_q <= cnt_q + CW'(1);
				end
				OP_SORT_START: size_q <= cnt_q;
				OP_UP_MOVE:    pos_q  <= parent;
				OP_RND_MOVE: begin
					size_q <= size_q - CW'(1);
					pos_q  <= '0;
				end
				OP_DN_TAKE_LD, OP_DN_TAKE_L: pos_q <= l_idx[AW-1:0];
				OP_DN_TAKE_R:  pos_q <= r_idx[AW-1:0];
				OP_DRN_START:  pos_q <= '0;
				OP_RES_DRN: begin
					pos_q <= pos_q + AW'(1);
					if (stat.drn_last) begin
						cnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			OP_INS_START: begin
				mkey_q <= key;
				drop_q <= 1'b0;
			end
			OP_DROP:       drop_q <= 1'b1;
			OP_EMPTY:      drop_q <= 1'b0;
			OP_RND_RDROOT: mkey_q <= rdata;
			OP_DN_RDR:     lval_q <= rdata;
			OP_RES_INS: begin
				out_value   <= '0;
				out_vflag   <= 1'b0;
				out_last    <= 1'b1;
				out_count   <= COUNT_W'(cnt_q);
				out_dropped <= drop_q;
			end
			OP_RES_DRN: begin
				out_value   <= rdata;
				out_vflag   <= 1'b1;
				out_last    <= stat.drn_last;
				out_count   <= '0;
				out_dropped <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// count never exceeds capacity, heap never larger than the count
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");
	a_size_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= cnt_q)
		else $error("heap size above entry count");

endmodule

// ===== design/mhpq_ctrl.sv =====
// Controller FSM for the heap core: sequences insert sift-up, heapsort
// rounds with sift-down, and the ascending drain. Issues one micro-op a cycle.
// Depends on mhpq_pkg.
module mhpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_mode,
	output logic               s_tready,
	input  logic               m_tready,
	output logic               m_tvalid,
	input  mhpq_pkg::dp_stat_t stat,
	output mhpq_pkg::dp_op_e   op
);
	import mhpq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_RES,
		ST_RND,
		ST_RND_R1,
		ST_RND_R2,
		ST_DN_CHK,
		ST_DN_L,
		ST_DN_R,
		ST_DRN_RD,
		ST_DRN_OUT
	} state_t;

	state_t state_q, state_d;
	logic   rdy_q, vld_q;
	logic   out_free;

	assign s_tready = rdy_q;
	assign m_tvalid = vld_q;
	assign out_free = !vld_q || m_tready;

	// next state and micro-op
	always_comb begin
		state_d = state_q;
		op      = OP_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && rdy_q) begin
					if (!s_mode) begin
						if (stat.full) begin
							op      = OP_DROP;
							state_d = ST_RES;
						end else begin
							op      = OP_INS_START;
							state_d = ST_UP_CHK;
						end
					end else if (stat.empty) begin
						op      = OP_EMPTY;
						state_d = ST_RES;
					end else begin
						op      = OP_SORT_START;
						state_d = ST_RND;
					end
				end
			end
			// sift-up
			ST_UP_CHK: begin
				if (stat.pos_zero) begin
					op      = OP_PUT;
					state_d = ST_RES;
				end else begin
					op      = OP_UP_READ;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (stat.up_gt) begin
					op      = OP_UP_MOVE;
					state_d = ST_UP_CHK;
				end else begin
					op      = OP_PUT;
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				if (out_free) begin
					op      = OP_RES_INS;
					state_d = ST_IDLE;
				end
			end
			// heapsort round: root to the end, last entry sifts down
			ST_RND: begin
				if (stat.size_zero) begin
					op      = OP_DRN_START;
					state_d = ST_DRN_RD;
				end else begin
					op      = OP_RND_RDLAST;
					state_d = ST_RND_R1;
				end
			end
			ST_RND_R1: begin
				op      = OP_RND_RDROOT;
				state_d = ST_RND_R2;
			end
			ST_RND_R2: begin
				op      = OP_RND_MOVE;
				state_d = ST_DN_CHK;
			end
			// sift-down
			ST_DN_CHK: begin
				if (stat.l_in) begin
					op      = OP_DN_RDL;
					state_d = ST_DN_L;
				end else begin
					op      = OP_PUT;
					state_d = ST_RND;
				end
			end
			ST_DN_L: begin
				if (stat.r_in) begin
					op      = OP_DN_RDR;
					state_d = ST_DN_R;
				end else if (stat.rd_gt) begin
					op      = OP_DN_TAKE_LD;
					state_d = ST_DN_CHK;
				end else begin
					op      = OP_PUT;
					state_d = ST_RND;
				end
			end
			ST_DN_R: begin
				// right child wins ties
				if (!stat.lv_gt && !stat.rd_gt) begin
					op      = OP_PUT;
					state_d = ST_RND;
				end else if (stat.lr_gt) begin
					op      = OP_DN_TAKE_L;
					state_d = ST_DN_CHK;
				end else begin
					op      = OP_DN_TAKE_R;
					state_d = ST_DN_CHK;
				end
			end
			// drain in ascending order
			ST_DRN_RD: begin
				op      = OP_DRN_READ;
				state_d = ST_DRN_OUT;
			end
			ST_DRN_OUT: begin
				if (out_free) begin
					op      = OP_RES_DRN;
					state_d = stat.drn_last ? ST_IDLE : ST_DRN_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rdy_q   <= (state_d == ST_IDLE);
			if (op == OP_RES_INS || op == OP_RES_DRN) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (state_q == ST_IDLE))
		else $error("item accepted outside idle");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_RES_INS || op == OP_RES_DRN) |-> (!vld_q || m_tready))
		else $error("output register overwritten while held");
	a_dnr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DN_R) |-> stat.r_in)
		else $error("right child compare outside heap");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for max_heap_priority_queue_sort_core: inserts and sort drains of signed keys.
// A heap predictor built into the bench sets the expected result items, which are
// checked field by field. Depends on mhpq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

	import mhpq_pkg::*;

	localparam int HEAP_DEPTH   = DEF_CAPACITY;
	localparam int IDLE_LIMIT   = 8000;  // cycles with no handshake before giving up
	localparam int TAIL_CYCLES  = 60;    // extra cycles after the last expected item
	localparam int RANDOM_ITEMS = 64;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SORT   = 1'b1;

	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;

	// One result item as the core should send it
	typedef struct packed {
		logic signed [KEY_W-1:0] value;
		logic                    value_valid;
		logic                    last;
		logic [COUNT_W-1:0]      count;
		logic                    dropped;
	} heap_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;  // [31:0] key
	logic                  s_tuser  = 1'b0; // [0] mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;  // [31:0] value, [37:32] count, [38] dropped, [39] zero
	logic                  m_tuser;  // [0] value_valid
	logic                  m_tlast;

	// Predictor state: heap array and number of held keys
	logic signed [KEY_W-1:0] shadow_heap [HEAP_DEPTH];
	int unsigned             shadow_count = 0;

	heap_result_t expected_results [$];

	int  err_count      = 0;
	int  inserts_sent   = 0;
	int  drops_seen     = 0;
	int  sorts_sent     = 0;
	int  empty_sorts    = 0;
	int  keys_drained   = 0;
	int  results_seen   = 0;
	int  idle_cycles    = 0;
	bit  steady_run     = 1'b0;  // no idling on either side while set

	always #1 clk = ~clk;

	max_heap_priority_queue_sort_core #(
		.CAPACITY(HEAP_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// Mismatch reporting: one line each, all counted
	task automatic report_mismatch(input string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function automatic void push_result(logic signed [KEY_W-1:0] value, logic vv, logic last,
	                                    int unsigned count, logic dropped);
		heap_result_t r;
		r.value       = value;
		r.value_valid = vv;
		r.last        = last;
		r.count       = count[COUNT_W-1:0];
		r.dropped     = dropped;
		expected_results.push_back(r);
	endfunction

	function automatic void swap_shadow(int unsigned a, int unsigned b);
		logic signed [KEY_W-1:0] t;
		t              = shadow_heap[a];
		shadow_heap[a] = shadow_heap[b];
		shadow_heap[b] = t;
	endfunction

	// Insert: append and climb while strictly greater than the parent
	function automatic void heap_insert(logic signed [KEY_W-1:0] key);
		int unsigned pos;
		int unsigned parent;
		if (shadow_count >= HEAP_DEPTH) begin
			push_result('0, 1'b0, 1'b1, shadow_count, 1'b1);
			drops_seen++;
			return;
		end
		pos              = shadow_count;
		shadow_heap[pos] = key;
		shadow_count++;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (!(shadow_heap[pos] > shadow_heap[parent]))
				break;
			swap_shadow(pos, parent);
			pos = parent;
		end
		push_result('0, 1'b0, 1'b1, shadow_count, 1'b0);
	endfunction

	// Sift the root down within the first 'size' entries; right child wins ties
	function automatic void sift_root(int unsigned size);
		int unsigned idx;
		int unsigned lc;
		int unsigned rc;
		bit          lbig;
		bit          rbig;
		idx = 0;
		while (2 * idx + 1 < size) begin
			lc = 2 * idx + 1;
			rc = lc + 1;
			if (rc >= size) begin
				if (shadow_heap[lc] > shadow_heap[idx]) begin
					swap_shadow(idx, lc);
					idx = lc;
				end else begin
					break;
				end
			end else begin
				lbig = shadow_heap[lc] > shadow_heap[idx];
				rbig = shadow_heap[rc] > shadow_heap[idx];
				if (!lbig && !rbig)
					break;
				if (shadow_heap[lc] > shadow_heap[rc]) begin
					swap_shadow(idx, lc);
					idx = lc;
				end else begin
					swap_shadow(idx, rc);
					idx = rc;
				end
			end
		end
	endfunction

	// Sort: heapsort in place, then every key ascending, heap left empty
	function automatic void heap_sort_drain();
		int unsigned total;
		int unsigned size;
		total = shadow_count;
		if (total == 0) begin
			push_result('0, 1'b0, 1'b1, 0, 1'b0);
			empty_sorts++;
			return;
		end
		size = total;
		while (size > 0) begin
			swap_shadow(0, size - 1);
			size--;
			sift_root(size);
		end
		shadow_count = 0;
		for (int unsigned j = 0; j < total; j++) begin
			push_result(shadow_heap[j], 1'b1, (j + 1 == total), 0, 1'b0);
			keys_drained++;
		end
	endfunction

	// Send one item; predict at the edge where it is taken
	task automatic send_item(input logic mode, input logic [KEY_W-1:0] key);
		if (!steady_run) begin
			while ($urandom_range(0, 99) < 25) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (mode == MODE_INSERT) begin
			inserts_sent++;
			heap_insert(key);
		end else begin
			sorts_sent++;
			heap_sort_drain();
		end
	endtask

	// Key mix: extremes, a narrow band for duplicates, and full-width values
	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			case ($urandom_range(0, 3))
				0:       return KEY_MAX;
				1:       return KEY_MIN;
				2:       return '0;
				default: return '1;
			endcase
		end else if (sel <= 3) begin
			return KEY_W'($signed($urandom_range(0, 16)) - 8);
		end
		return $urandom;
	endfunction

	// Sort of an empty heap, right after reset
	task automatic test_empty_sort();
		send_item(MODE_SORT, $urandom);
	endtask

	// Extremes, duplicates, ascending keys that climb but stay below the root, tiny heaps
	task automatic test_key_extremes();
		send_item(MODE_INSERT, KEY_MAX);
		send_item(MODE_INSERT, KEY_MIN);
		send_item(MODE_INSERT, '0);
		send_item(MODE_INSERT, '1);
		send_item(MODE_INSERT, 32'h0000_0001);
		send_item(MODE_INSERT, 32'h8000_0001);
		send_item(MODE_INSERT, 32'h7FFF_FFFE);
		repeat (3) send_item(MODE_INSERT, 32'h0000_0005);
		send_item(MODE_INSERT, 32'h0000_0010);
		send_item(MODE_INSERT, 32'h0000_0020);
		send_item(MODE_INSERT, 32'h0000_0030);
		send_item(MODE_SORT, '1);
		// single key, then two equal keys
		send_item(MODE_INSERT, KEY_MIN);
		send_item(MODE_SORT, '0);
		send_item(MODE_INSERT, KEY_MAX);
		send_item(MODE_INSERT, KEY_MAX);
		send_item(MODE_SORT, $urandom);
		// sort twice in a row: the second finds the heap empty
		send_item(MODE_SORT, $urandom);
	endtask

	// Fill to capacity with no idling, overflow twice, then drain
	task automatic test_full_heap();
		steady_run = 1'b1;
		for (int i = 0; i < HEAP_DEPTH + 2; i++) begin
			send_item(MODE_INSERT, pick_key());
		end
		send_item(MODE_SORT, $urandom);
		steady_run = 1'b0;
	endtask

	// Random runs of inserts closed by a sort; mostly short, some past capacity
	task automatic test_random_runs();
		int sent;
		int run_len;
		int sel;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 7)
				run_len = $urandom_range(1, 6);
			else if (sel < 9)
				run_len = $urandom_range(7, 20);
			else
				run_len = $urandom_range(HEAP_DEPTH - 2, HEAP_DEPTH + 3);
			for (int i = 0; i < run_len; i++) begin
				send_item(MODE_INSERT, pick_key());
			end
			send_item(MODE_SORT, $urandom);
			sent += run_len + 1;
			if ($urandom_range(0, 9) == 0) begin
				send_item(MODE_SORT, $urandom);
				sent++;
			end
		end
	endtask

	// Receiver side: random back-pressure
	always @(posedge clk) begin
		m_tready <= steady_run || ($urandom_range(0, 99) >= 25);
	end

	// Compare each taken result item with the oldest expectation
	always @(posedge clk) begin : result_check
		heap_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected item tdata=%h tuser=%b tlast=%b",
				                          m_tdata, m_tuser, m_tlast));
			end else begin
				exp_r = expected_results.pop_front();
				if (m_tdata[KEY_W-1:0] !== exp_r.value)
					report_mismatch($sformatf("item %0d value exp %h got %h", results_seen,
					                          exp_r.value, m_tdata[KEY_W-1:0]));
				if (m_tuser !== exp_r.value_valid)
					report_mismatch($sformatf("item %0d value_valid exp %b got %b",
					                          results_seen, exp_r.value_valid, m_tuser));
				if (m_tlast !== exp_r.last)
					report_mismatch($sformatf("item %0d last exp %b got %b", results_seen,
					                          exp_r.last, m_tlast));
				if (m_tdata[KEY_W +: COUNT_W] !== exp_r.count)
					report_mismatch($sformatf("item %0d count exp %0d got %0d", results_seen,
					                          exp_r.count, m_tdata[KEY_W +: COUNT_W]));
				if (m_tdata[KEY_W+COUNT_W] !== exp_r.dropped)
					report_mismatch($sformatf("item %0d dropped exp %b got %b", results_seen,
					                          exp_r.dropped, m_tdata[KEY_W+COUNT_W]));
			end
		end
	end

	// Watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d items still expected",
				         IDLE_LIMIT, expected_results.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_sort();
		test_key_extremes();
		test_full_heap();
		test_random_runs();

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d inserts (%0d refused on a full heap), %0d sorts (%0d on empty heap)",
		         inserts_sent, drops_seen, sorts_sent, empty_sorts);
		$display("run: %0d keys drained in order, %0d result items checked, %0d mismatches",
		         keys_drained, results_seen, err_count);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
